// ===== src/nlsl_pkg.sv =====
// Shared types, constants and helpers for the night light schedule level block.
// Used by every module under src; depends on nothing.
package nlsl_pkg;

  localparam logic [10:0]        DayMinutes   = 11'd1440;
  localparam logic [11:0]        DayMinutesW  = 12'd1440;
  localparam logic signed [12:0] DayMinutesS  = 13'sd1440;
  localparam logic [10:0]        WrapBack     = 11'd1410;
  localparam logic [10:0]        PreSunrise   = 11'd30;
  localparam int unsigned        DivCells     = 8;
  localparam int unsigned        NumW         = 19;

  typedef enum logic [2:0] {
    PH_DAY_OFF   = 3'd0,
    PH_FADE_UP   = 3'd1,
    PH_PEAK      = 3'd2,
    PH_FADE_DN   = 3'd3,
    PH_NIGHT     = 3'd4,
    PH_NIGHT_OFF = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CFG_COLOR = 3'd0,
    CFG_MAX   = 3'd1,
    CFG_NIGHT = 3'd2,
    CFG_START = 3'd3,
    CFG_PEAK  = 3'd4,
    CFG_DIM   = 3'd5,
    CFG_OFF   = 3'd6,
    CFG_FADE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        color_word;
    logic [7:0]         max_level;
    logic [7:0]         night_level;
    logic signed [11:0] start_minute;
    logic [10:0]        peak_minute;
    logic [10:0]        dim_minute;
    logic signed [11:0] off_minute;
    logic [7:0]         fade_minutes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      hue;
    logic [7:0]      sat;
    phase_e          phase;
    logic [7:0]      level;
    logic [7:0]      max_level;
    logic [7:0]      amount;
    logic [10:0]     el;
    logic [10:0]     dur;
    logic [NumW-1:0] rem;
    logic [NumW-1:0] dsh;
    logic [7:0]      quo;
  } item_t;

  function automatic logic in_span(logic [10:0] c, logic [10:0] s, logic [10:0] e);
    logic r;
    if (s <= e) begin
      r = (c >= s) && (c < e);
    end else begin
      r = (c >= s) || (c < e);
    end
    return r;
  endfunction

endpackage

// ===== src/nlsl_classify.sv =====
// Front stage: resolves schedule minutes, picks the phase and the range progress.
// Depends on nlsl_pkg.
module nlsl_classify (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nlsl_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 time_valid_i,
  input  logic [10:0]          minute_i,
  input  logic [10:0]          sunrise_i,
  input  logic [10:0]          sunset_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output nlsl_pkg::item_t      item_o
);

  logic            valid_q;
  nlsl_pkg::item_t item_q, item_d;

  logic [10:0]        start_min, off_min, off_auto, fade_end, night_start;
  logic [11:0]        fade_sum;
  logic [10:0]        sel_s, sel_e;
  logic signed [12:0] c_x, s_x, e_x, ds, es;

  always_comb begin
    start_min = cfg_i.start_minute[11] ? sunset_i : cfg_i.start_minute[10:0];
    off_auto  = (sunrise_i >= nlsl_pkg::PreSunrise) ? sunrise_i - nlsl_pkg::PreSunrise
                                                     : sunrise_i + nlsl_pkg::WrapBack;
    off_min   = cfg_i.off_minute[11] ? off_auto : cfg_i.off_minute[10:0];
    fade_sum  = {1'b0, cfg_i.dim_minute} + {4'b0, cfg_i.fade_minutes};
    fade_end  = (fade_sum >= nlsl_pkg::DayMinutesW) ? 11'(fade_sum - nlsl_pkg::DayMinutesW)
                                                    : fade_sum[10:0];
    night_start = (cfg_i.fade_minutes != 8'd0) ? fade_end : cfg_i.dim_minute;
  end

  always_comb begin
    item_d           = '0;
    item_d.hue       = cfg_i.color_word[7:0];
    item_d.sat       = cfg_i.color_word[15:8];
    item_d.max_level = cfg_i.max_level;
    item_d.phase     = nlsl_pkg::PH_DAY_OFF;
    item_d.level     = 8'd0;
    sel_s            = start_min;
    sel_e            = cfg_i.peak_minute;
    item_d.amount    = 8'd0;
    priority if (!time_valid_i) begin
      item_d.phase = nlsl_pkg::PH_DAY_OFF;
    end else if (nlsl_pkg::in_span(minute_i, sunrise_i, start_min)) begin
      item_d.phase = nlsl_pkg::PH_DAY_OFF;
    end else if (nlsl_pkg::in_span(minute_i, start_min, cfg_i.peak_minute)) begin
      item_d.phase  = nlsl_pkg::PH_FADE_UP;
      item_d.amount = cfg_i.max_level;
    end else if (nlsl_pkg::in_span(minute_i, cfg_i.peak_minute, cfg_i.dim_minute)) begin
      item_d.phase = nlsl_pkg::PH_PEAK;
      item_d.level = cfg_i.max_level;
    end else if ((cfg_i.fade_minutes != 8'd0) &&
                 nlsl_pkg::in_span(minute_i, cfg_i.dim_minute, fade_end)) begin
      item_d.phase  = nlsl_pkg::PH_FADE_DN;
      item_d.amount = cfg_i.max_level - cfg_i.night_level;
      sel_s         = cfg_i.dim_minute;
      sel_e         = fade_end;
    end else if (nlsl_pkg::in_span(minute_i, night_start, off_min)) begin
      item_d.phase = nlsl_pkg::PH_NIGHT;
      item_d.level = cfg_i.night_level;
    end else begin
      item_d.phase = nlsl_pkg::PH_NIGHT_OFF;
    end

    c_x = $signed({2'b0, minute_i});
    s_x = $signed({2'b0, sel_s});
    e_x = $signed({2'b0, sel_e});
    ds  = (sel_s <= sel_e) ? e_x - s_x : nlsl_pkg::DayMinutesS - s_x + e_x;
    es  = ((sel_s <= sel_e) || (minute_i >= sel_s)) ? c_x - s_x
                                                    : c_x + nlsl_pkg::DayMinutesS - s_x;
    if (ds > 13'sd0) begin
      item_d.dur = ds[10:0];
      if (es < 13'sd0) begin
        item_d.el = 11'd0;
      end else if (es > ds) begin
        item_d.el = ds[10:0];
      end else begin
        item_d.el = es[10:0];
      end
    end else begin
      item_d.dur = 11'd1;
      item_d.el  = 11'd1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/nlsl_mul.sv =====
// Product stage: forms the dividend amount times elapsed and aligns the divisor.
// Depends on nlsl_pkg.
module nlsl_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  nlsl_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output nlsl_pkg::item_t item_o
);

  logic            valid_q;
  nlsl_pkg::item_t item_q, item_d;

  always_comb begin
    item_d     = item_i;
    item_d.rem = nlsl_pkg::NumW'({11'd0, item_i.amount} * item_i.el);
    item_d.dsh = {1'b0, item_i.dur, 7'd0};
    item_d.quo = 8'd0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/nlsl_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit and hands the item on.
// Depends on nlsl_pkg.
module nlsl_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  nlsl_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output nlsl_pkg::item_t item_o
);

  logic            valid_q;
  nlsl_pkg::item_t item_q, item_d;

  always_comb begin
    item_d = item_i;
    if (item_i.rem >= item_i.dsh) begin
      item_d.rem = item_i.rem - item_i.dsh;
      item_d.quo = {item_i.quo[6:0], 1'b1};
    end else begin
      item_d.quo = {item_i.quo[6:0], 1'b0};
    end
    item_d.dsh = {1'b0, item_i.dsh[nlsl_pkg::NumW-1:1]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/nlsl_finish.sv =====
// Output stage: sets the lamp level (quotient in fades) and holds the result.
// Depends on nlsl_pkg.
module nlsl_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  nlsl_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      hue_o,
  output logic [7:0]      sat_o,
  output logic [7:0]      level_o,
  output logic [2:0]      phase_o
);

  logic       valid_q;
  logic [7:0] hue_q, sat_q, level_q, level_d;
  logic [2:0] phase_q;

  always_comb begin
    unique case (item_i.phase)
      nlsl_pkg::PH_FADE_UP: level_d = item_i.quo;
      nlsl_pkg::PH_FADE_DN: level_d = item_i.max_level - item_i.quo;
      default:              level_d = item_i.level;
    endcase
  end

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q   <= item_i.hue;
      sat_q   <= item_i.sat;
      level_q <= level_d;
      phase_q <= item_i.phase;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign level_o = level_q;
  assign phase_o = phase_q;

endmodule

// ===== src/night_light_schedule_level_top.sv =====
// Top level of the night light schedule level block: config registers and the stage chain.
// Depends on nlsl_pkg, nlsl_classify, nlsl_mul, nlsl_div_cell and nlsl_finish.
//
// Usage: one request per tick on the input channel (in_valid_i / in_stall_o) carries
// time_valid, minute of day, sunrise and sunset. Each request yields exactly one
// result on the output channel (out_valid_o / out_stall_i): hue, saturation,
// brightness and phase.
// Each accepted request passes through one classify stage, one product stage, eight
// divider cells (one quotient bit each) and the output register, whose valid flag
// drives out_valid_o.
// Throughput is one request per cycle while in_stall_o is low; every stage of the chain is a register.
// A stage takes a new request when it is empty or its successor takes its item,
// so bubbles close up and input keeps flowing while a result waits on a stall.
// When the receiver stalls, the result holds and the chain fills behind it; after
// eleven items in flight in_stall_o rises.
// Reset empties the chain and loads the default schedule registers. Write the
// registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while the chain is empty.
module night_light_schedule_level_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        time_valid_i,
  input  logic [10:0] minute_of_day_i,
  input  logic [10:0] sunrise_minute_i,
  input  logic [10:0] sunset_minute_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  hue_out_o,
  output logic [7:0]  saturation_out_o,
  output logic [7:0]  brightness_o,
  output logic [2:0]  phase_o
);

  nlsl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_word   <= 16'd206;
      cfg_q.max_level    <= 8'd255;
      cfg_q.night_level  <= 8'd30;
      cfg_q.start_minute <= -12'sd1;
      cfg_q.peak_minute  <= 11'd1260;
      cfg_q.dim_minute   <= 11'd1290;
      cfg_q.off_minute   <= -12'sd1;
      cfg_q.fade_minutes <= 8'd30;
    end else if (cfg_we_i) begin
      unique case (nlsl_pkg::cfg_idx_e'(cfg_idx_i))
        nlsl_pkg::CFG_COLOR: cfg_q.color_word   <= cfg_wdata_i;
        nlsl_pkg::CFG_MAX:   cfg_q.max_level    <= cfg_wdata_i[7:0];
        nlsl_pkg::CFG_NIGHT: cfg_q.night_level  <= cfg_wdata_i[7:0];
        nlsl_pkg::CFG_START: cfg_q.start_minute <= $signed(cfg_wdata_i[11:0]);
        nlsl_pkg::CFG_PEAK:  cfg_q.peak_minute  <= cfg_wdata_i[10:0];
        nlsl_pkg::CFG_DIM:   cfg_q.dim_minute   <= cfg_wdata_i[10:0];
        nlsl_pkg::CFG_OFF:   cfg_q.off_minute   <= $signed(cfg_wdata_i[11:0]);
        nlsl_pkg::CFG_FADE:  cfg_q.fade_minutes <= cfg_wdata_i[7:0];
        default:             cfg_q.fade_minutes <= cfg_q.fade_minutes;
      endcase
    end
  end

  logic            cls_ready, cls_valid, mul_ready;
  nlsl_pkg::item_t cls_item;
  logic            div_valid [nlsl_pkg::DivCells+1];
  logic            div_ready [nlsl_pkg::DivCells+1];
  nlsl_pkg::item_t div_item  [nlsl_pkg::DivCells+1];

  nlsl_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (in_valid_i),
    .ready_o      (cls_ready),
    .time_valid_i (time_valid_i),
    .minute_i     (minute_of_day_i),
    .sunrise_i    (sunrise_minute_i),
    .sunset_i     (sunset_minute_i),
    .valid_o      (cls_valid),
    .ready_i      (mul_ready),
    .item_o       (cls_item)
  );

  nlsl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .ready_o (mul_ready),
    .item_i  (cls_item),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .item_o  (div_item[0])
  );

  for (genvar k = 0; k < nlsl_pkg::DivCells; k++) begin : g_cell
    nlsl_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .item_i  (div_item[k]),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .item_o  (div_item[k+1])
    );
  end

  nlsl_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[nlsl_pkg::DivCells]),
    .ready_o (div_ready[nlsl_pkg::DivCells]),
    .item_i  (div_item[nlsl_pkg::DivCells]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .hue_o   (hue_out_o),
    .sat_o   (saturation_out_o),
    .level_o (brightness_o),
    .phase_o (phase_o)
  );

  assign in_stall_o = !cls_ready;

endmodule

// ===== src/nlsl_checker.sv =====
// Port-level checks for the night light schedule level block, bound to its top level.
// Depends on nlsl_pkg and night_light_schedule_level_top.
module nlsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] brightness_o,
  input logic [2:0] phase_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_o) && $stable(brightness_o))
    else $error("stalled result changed");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> phase_o <= 3'(nlsl_pkg::PH_NIGHT_OFF))
    else $error("phase code out of range");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == 3'(nlsl_pkg::PH_DAY_OFF) ||
                    phase_o == 3'(nlsl_pkg::PH_NIGHT_OFF)) |-> brightness_o == 8'd0)
    else $error("lamp lit in an off phase");

endmodule

bind night_light_schedule_level_top nlsl_checker u_nlsl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .brightness_o (brightness_o),
  .phase_o      (phase_o)
);
